// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define VWIM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vwim: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define VWIM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vwim: next-cycle check failed");

`endif

// ===== sv/vwim_pkg.sv =====
package vwim_pkg;

  localparam int COORD_W   = 24;
  localparam int MAG_W     = 24;
  localparam int DIST_W    = 26;
  localparam int THRESH_W  = 26;
  localparam int WELD_W    = 10;
  localparam int NUM_CELLS = 8;
  localparam int CELL_BITS = 3;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    logic                 hit;
    logic [CELL_BITS-1:0] lane;
  } chain_t;

endpackage

// ===== sv/vwim_ram.sv =====
module vwim_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/vwim_cell.sv =====
module vwim_cell #(
  parameter int LANE  = 0,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  vwim_pkg::vertex_t                 wr_data,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  input  logic                              lane_en,
  input  vwim_pkg::vertex_t                 query,
  input  logic [vwim_pkg::THRESH_W-1:0]     threshold,
  input  vwim_pkg::chain_t                  chain_in,
  output vwim_pkg::chain_t                  chain_out
);

  import vwim_pkg::*;

  vertex_t            rd_data;
  logic [MAG_W-1:0]   ax;
  logic [MAG_W-1:0]   ay;
  logic [MAG_W-1:0]   az;
  logic               a_en;
  logic [DIST_W-1:0]  l1_sum;
  logic               b_hit;

  function automatic logic [MAG_W-1:0] absdiff(coord_t a, coord_t b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

  vwim_ram #(
    .WIDTH ($bits(vertex_t)),
    .DEPTH (DEPTH)
  ) u_bank (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign l1_sum = DIST_W'(ax) + DIST_W'(ay) + DIST_W'(az);

  always_ff @(posedge clk) begin
    ax    <= absdiff(query.x, rd_data.x);
    ay    <= absdiff(query.y, rd_data.y);
    az    <= absdiff(query.z, rd_data.z);
    a_en  <= lane_en;
    b_hit <= a_en && (l1_sum < threshold);
  end

  assign chain_out.hit  = chain_in.hit | b_hit;
  assign chain_out.lane = chain_in.hit ? chain_in.lane : CELL_BITS'(LANE);

endmodule

// ===== sv/vertex_weld_index_mapper_top.sv =====
// Vertex weld index mapper.
// Input channel vtx_valid/vtx_ready carries one vertex (coord_x, coord_y,
// coord_z, signed Q15.8) and mesh_end. Output channel weld_valid/weld_ready
// returns one result per vertex: weld_index, the first earlier vertex of the
// mesh within L1 distance below match_threshold, else the vertex's own index,
// and overflow when the store was already full (weld_index is then 0).
// cfg_wr_en/cfg_wr_data write match_threshold; write it only while idle.
// The store is split over eight cells, vertex j in cell j mod 8, row j / 8.
// Each cycle one row is read and eight distances are checked in the chain.
// An item with stored vertices is scanned before the store write, and the
// scan ends early when a match is found; an empty store skips the scan and a
// full store skips both the scan and the write.
// The scan stops at the first row that holds a match.
// One item is handled at a time; vtx_ready is high only while idle.
// A finished result waits in the output register while the next vertex is
// taken; if weld_ready stays low, the block holds the next result and stalls.
// Reset clears the vertex count, sets match_threshold to 1 and empties the
// output register; store contents are left as they are.
module vertex_weld_index_mapper_top #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [vwim_pkg::THRESH_W-1:0]       cfg_wr_data,
  input  logic                                vtx_valid,
  output logic                                vtx_ready,
  input  logic signed [vwim_pkg::COORD_W-1:0] coord_x,
  input  logic signed [vwim_pkg::COORD_W-1:0] coord_y,
  input  logic signed [vwim_pkg::COORD_W-1:0] coord_z,
  input  logic                                mesh_end,
  output logic                                weld_valid,
  input  logic                                weld_ready,
  output logic [vwim_pkg::WELD_W-1:0]         weld_index,
  output logic                                overflow
);

  import vwim_pkg::*;

  localparam int ROWS = (MAX_VERTICES + NUM_CELLS - 1) / NUM_CELLS;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (RW + CELL_BITS > CNTW) ? RW + CELL_BITS : CNTW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t               state;
  logic [CNTW-1:0]      count;
  logic [THRESH_W-1:0]  threshold;
  vertex_t              query;
  logic                 q_last;
  logic [RW-1:0]        row;
  logic [RW-1:0]        last_row;
  logic                 issue_done;
  logic                 p1_v;
  logic                 p2_v;
  logic                 p3_v;
  logic [RW-1:0]        p1_row;
  logic [RW-1:0]        p2_row;
  logic [RW-1:0]        p3_row;
  logic [NUM_CELLS-1:0] p1_mask;
  logic [WELD_W-1:0]    res_idx;
  logic                 res_ovf;

  logic [CMPW-1:0]      n_ext;
  logic [CMPW-1:0]      n_m1;
  logic                 rd_en;
  logic [NUM_CELLS-1:0] mask;
  chain_t               chain [NUM_CELLS+1];
  logic                 hit_found;
  logic [CMPW-1:0]      hit_idx;
  logic                 scan_end;
  logic                 out_load;
  vertex_t              vtx_in;

  assign n_ext     = CMPW'(count);
  assign n_m1      = n_ext - CMPW'(1);
  assign rd_en     = (state == S_SCAN) && !issue_done;
  assign hit_found = p3_v && chain[NUM_CELLS].hit;
  assign hit_idx   = CMPW'({p3_row, chain[NUM_CELLS].lane});
  assign scan_end  = issue_done && !p1_v && !p2_v && !p3_v;
  assign out_load  = (state == S_DONE) && (!weld_valid || weld_ready);
  assign vtx_ready = (state == S_IDLE);
  assign vtx_in    = '{x: coord_x, y: coord_y, z: coord_z};

  always_comb begin
    for (int k = 0; k < NUM_CELLS; k++) begin
      mask[k] = CMPW'({row, CELL_BITS'(k)}) < n_ext;
    end
  end

  assign chain[0] = '{hit: 1'b0, lane: '0};

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    vwim_cell #(
      .LANE  (k),
      .DEPTH (ROWS)
    ) u_cell (
      .clk       (clk),
      .wr_en     ((state == S_WRITE) && (n_ext[CELL_BITS-1:0] == CELL_BITS'(k))),
      .wr_addr   (n_ext[RW+CELL_BITS-1:CELL_BITS]),
      .wr_data   (query),
      .rd_en     (rd_en),
      .rd_addr   (row),
      .lane_en   (p1_mask[k]),
      .query     (query),
      .threshold (threshold),
      .chain_in  (chain[k]),
      .chain_out (chain[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      threshold  <= THRESH_W'(1);
      issue_done <= 1'b1;
      p1_v       <= 1'b0;
      p2_v       <= 1'b0;
      p3_v       <= 1'b0;
      p1_mask    <= '0;
      weld_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
      if (weld_valid && weld_ready && !out_load) begin
        weld_valid <= 1'b0;
      end

      p1_v    <= rd_en && !hit_found;
      p1_row  <= row;
      p1_mask <= (rd_en && !hit_found) ? mask : '0;
      p2_v    <= p1_v && !hit_found;
      p2_row  <= p1_row;
      p3_v    <= p2_v && !hit_found;
      p3_row  <= p2_row;

      case (state)
        S_IDLE: begin
          if (vtx_valid) begin
            query  <= vtx_in;
            q_last <= mesh_end;
            if (count >= CNTW'(MAX_VERTICES)) begin
              res_idx <= '0;
              res_ovf <= 1'b1;
              state   <= S_DONE;
            end else if (count == '0) begin
              res_idx <= '0;
              res_ovf <= 1'b0;
              state   <= S_WRITE;
            end else begin
              res_ovf    <= 1'b0;
              row        <= '0;
              last_row   <= n_m1[RW+CELL_BITS-1:CELL_BITS];
              issue_done <= 1'b0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en && (row != last_row)) begin
            row <= row + RW'(1);
          end
          if (hit_found) begin
            res_idx    <= WELD_W'(hit_idx);
            issue_done <= 1'b1;
            state      <= S_WRITE;
          end else if (scan_end) begin
            res_idx <= WELD_W'(count);
            state   <= S_WRITE;
          end else if (rd_en && (row == last_row)) begin
            issue_done <= 1'b1;
          end
        end
        S_WRITE: begin
          count <= count + CNTW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            weld_valid <= 1'b1;
            weld_index <= res_idx;
            overflow   <= res_ovf;
            if (q_last) begin
              count <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/vwim_checker.sv =====
`include "assert_macros.svh"

module vwim_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        vtx_valid,
  input logic                        vtx_ready,
  input logic                        weld_valid,
  input logic                        weld_ready,
  input logic [vwim_pkg::WELD_W-1:0] weld_index,
  input logic                        overflow
);

  `VWIM_ASSERT_IMPL(a_ovf_index_zero, weld_valid && overflow, weld_index == '0)
  `VWIM_ASSERT_NEXT(a_busy_after_transfer, vtx_valid && vtx_ready, !vtx_ready)
  `VWIM_ASSERT_IMPL(a_result_while_busy, $rose(weld_valid), $past(!vtx_ready))
  `VWIM_ASSERT_NEXT(a_stall_hold, weld_valid && !weld_ready, weld_valid && $stable(weld_index) && $stable(overflow))

endmodule

bind vertex_weld_index_mapper_top vwim_checker u_vwim_checker (.*);

// ===== dv/vertex_weld_index_mapper_top_tb.sv =====
module vertex_weld_index_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vwim_pkg::*;

  localparam int     MAX_VERTICES = 1024;
  localparam int     CYCLE_LIMIT  = 3_000_000;
  localparam int     TAIL_CYCLES  = 150;
  localparam int     HOLD_CYCLES  = 500;
  localparam int     RANDOM_ITEMS = 800;
  localparam coord_t COORD_MAX    = 24'sh7FFFFF;
  localparam coord_t COORD_MIN    = 24'sh800000;
  localparam logic [THRESH_W-1:0] THRESH_MAX   = '1;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 26'd1;

  typedef struct {
    logic [WELD_W-1:0] index;
    logic              ovf;
  } weld_t;

  typedef struct {
    bit                  cfg;
    logic [THRESH_W-1:0] thr;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic                last;
    bit                  typed;
    weld_t               want;
  } vec_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic [THRESH_W-1:0] cfg_wr_data = '0;
  logic                vtx_valid = 1'b0;
  logic                vtx_ready;
  coord_t              coord_x = '0;
  coord_t              coord_y = '0;
  coord_t              coord_z = '0;
  logic                mesh_end = 1'b0;
  logic                weld_valid;
  logic                weld_ready = 1'b0;
  logic [WELD_W-1:0]   weld_index;
  logic                overflow;

  // predictor state
  coord_t              mesh_x [MAX_VERTICES];
  coord_t              mesh_y [MAX_VERTICES];
  coord_t              mesh_z [MAX_VERTICES];
  int                  mesh_count = 0;
  logic [THRESH_W-1:0] weld_thresh = THRESH_RESET;

  weld_t    pending_welds [$];
  vec_row_t vec_table [$];
  int       errors = 0;
  int       results_seen = 0;
  int       next_hold_at = 300;
  int       hold_left = 0;
  int       send_idle = 37;
  int       recv_idle = 63;
  int       cycle_count = 0;

  vertex_weld_index_mapper_top #(
    .MAX_VERTICES(MAX_VERTICES)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .vtx_valid  (vtx_valid),
    .vtx_ready  (vtx_ready),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .mesh_end   (mesh_end),
    .weld_valid (weld_valid),
    .weld_ready (weld_ready),
    .weld_index (weld_index),
    .overflow   (overflow)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int axis_dist(input coord_t a, input coord_t b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  function automatic weld_t predict_weld(input coord_t x, input coord_t y, input coord_t z,
                                         input logic last);
    weld_t r;
    int    hit;
    int    l1_sum;
    if (mesh_count >= MAX_VERTICES) begin
      r.index = '0;
      r.ovf   = 1'b1;
    end else begin
      hit = mesh_count;
      // scan backwards so the lowest matching index wins
      for (int j = mesh_count - 1; j >= 0; j--) begin
        l1_sum = axis_dist(x, mesh_x[j]) + axis_dist(y, mesh_y[j]) + axis_dist(z, mesh_z[j]);
        if (l1_sum < int'(weld_thresh)) hit = j;
      end
      mesh_x[mesh_count] = x;
      mesh_y[mesh_count] = y;
      mesh_z[mesh_count] = z;
      mesh_count++;
      r.index = WELD_W'(hit);
      r.ovf   = 1'b0;
    end
    if (last) mesh_count = 0;
    return r;
  endfunction

  task automatic add_row(input bit cfg, input logic [THRESH_W-1:0] thr,
                         input coord_t x, input coord_t y, input coord_t z, input logic last,
                         input bit typed, input int idx, input logic ovf);
    vec_row_t row;
    row.cfg        = cfg;
    row.thr        = thr;
    row.x          = x;
    row.y          = y;
    row.z          = z;
    row.last       = last;
    row.typed      = typed;
    row.want.index = WELD_W'(idx);
    row.want.ovf   = ovf;
    vec_table.push_back(row);
  endtask

  // entered and left at a falling edge
  task automatic send_vertex(input coord_t x, input coord_t y, input coord_t z,
                             input logic last, input bit typed, input weld_t typed_want);
    weld_t pred;
    while ($urandom_range(99) < send_idle) begin
      vtx_valid <= 1'b0;
      @(negedge clk);
    end
    vtx_valid <= 1'b1;
    coord_x   <= x;
    coord_y   <= y;
    coord_z   <= z;
    mesh_end  <= last;
    do @(posedge clk); while (!vtx_ready);
    pred = predict_weld(x, y, z, last);
    pending_welds.push_back(typed ? typed_want : pred);
    @(negedge clk);
  endtask

  task automatic settle();
    vtx_valid <= 1'b0;
    while (pending_welds.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_thresh(input logic [THRESH_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    weld_thresh  = v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [THRESH_W-1:0] pick_thresh();
    case ($urandom_range(5))
      0:       return '0;
      1:       return THRESH_RESET;
      2:       return THRESH_MAX;
      3:       return THRESH_W'($urandom_range(2, 64));
      4:       return THRESH_W'($urandom_range(65, 4096));
      default: return THRESH_W'($urandom);
    endcase
  endfunction

  // receiver: random back-pressure plus long hold-offs
  initial begin
    forever begin
      @(negedge clk);
      if (results_seen >= next_hold_at) begin
        hold_left     = HOLD_CYCLES;
        next_hold_at += 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        weld_ready <= 1'b0;
      end else begin
        weld_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : weld_monitor
    weld_t want;
    if (!rst && weld_valid && weld_ready) begin
      results_seen++;
      if (pending_welds.size() == 0) begin
        $error("unexpected transfer: weld_index %0d overflow %0b", weld_index, overflow);
        errors++;
      end else begin
        want = pending_welds.pop_front();
        if (weld_index !== want.index) begin
          $error("weld_index: expected %0d, actual %0d", want.index, weld_index);
          errors++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %0b, actual %0b", want.ovf, overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    vec_row_t            row;
    weld_t               none;
    coord_t              hx [$];
    coord_t              hy [$];
    coord_t              hz [$];
    coord_t              bx, by, bz;
    coord_t              vx, vy, vz;
    logic                last;
    int                  sent;
    int                  mesh_len;
    int                  spread;
    int                  jit;
    int                  pick;
    int                  r;

    none.index = '0;
    none.ovf   = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // threshold 1 after reset
    add_row(0, '0, 0, 0, 0, 0, 1, 0, 0);
    add_row(0, '0, 0, 0, 0, 0, 1, 0, 0);
    add_row(0, '0, 1, 0, 0, 0, 1, 2, 0);
    add_row(0, '0, COORD_MAX, COORD_MAX, COORD_MAX, 0, 1, 3, 0);
    add_row(0, '0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 1, 4, 0);
    add_row(0, '0, COORD_MAX, COORD_MAX, COORD_MAX, 1, 1, 3, 0);
    add_row(0, '0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 1, 0, 0);
    // widest threshold covers the widest distance
    add_row(1, THRESH_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 1, 0, 0);
    add_row(0, '0, 0, 0, 0, 1, 1, 0, 0);
    // zero threshold never matches
    add_row(1, '0, 5, 5, 5, 0, 1, 0, 0);
    add_row(0, '0, 5, 5, 5, 0, 1, 1, 0);
    add_row(0, '0, 5, 5, 5, 1, 1, 2, 0);
    add_row(1, 26'd16, 100, -100, 0, 0, 1, 0, 0);
    add_row(0, '0, 105, -95, 5, 0, 1, 0, 0);
    add_row(0, '0, 110, -90, 10, 0, 0, 0, 0);
    add_row(0, '0, 121, -90, 10, 0, 0, 0, 0);
    add_row(0, '0, COORD_MIN, COORD_MAX, 0, 1, 0, 0, 0);
    // single-vertex meshes
    add_row(0, '0, 7, 7, 7, 1, 1, 0, 0);
    add_row(0, '0, 7, 7, 7, 1, 1, 0, 0);

    foreach (vec_table[i]) begin
      row = vec_table[i];
      if (row.cfg) begin
        settle();
        write_thresh(row.thr);
      end
      send_vertex(row.x, row.y, row.z, row.last, row.typed, row.want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent < RANDOM_ITEMS / 3) begin
        send_idle = 37;
        recv_idle = 63;
      end else if (sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 63;
        recv_idle = 37;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      settle();
      write_thresh(pick_thresh());
      jit = (weld_thresh > 3000) ? 1000 : int'(weld_thresh) / 2 + 1;
      repeat ($urandom_range(2, 6)) begin
        mesh_len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        spread   = $urandom_range(16, 1 << 20);
        bx = coord_t'($urandom);
        by = coord_t'($urandom);
        bz = coord_t'($urandom);
        hx.delete();
        hy.delete();
        hz.delete();
        for (int k = 0; k < mesh_len; k++) begin
          r    = $urandom_range(99);
          last = (k == mesh_len - 1);
          if (r < 8) begin
            // noise: anywhere, mesh may end early
            vx   = coord_t'($urandom);
            vy   = coord_t'($urandom);
            vz   = coord_t'($urandom);
            last = last | ($urandom_range(3) == 0);
          end else if (r < 50 && hx.size() != 0) begin
            pick = $urandom_range(hx.size() - 1);
            vx = coord_t'(int'(hx[pick]) + int'($urandom_range(0, 2 * jit)) - jit);
            vy = coord_t'(int'(hy[pick]) + int'($urandom_range(0, 2 * jit)) - jit);
            vz = coord_t'(int'(hz[pick]) + int'($urandom_range(0, 2 * jit)) - jit);
          end else begin
            vx = coord_t'(int'(bx) + int'($urandom_range(0, 2 * spread)) - spread);
            vy = coord_t'(int'(by) + int'($urandom_range(0, 2 * spread)) - spread);
            vz = coord_t'(int'(bz) + int'($urandom_range(0, 2 * spread)) - spread);
          end
          send_vertex(vx, vy, vz, last, 0, none);
          sent++;
          hx.push_back(vx);
          hy.push_back(vy);
          hz.push_back(vz);
          if (last) begin
            hx.delete();
            hy.delete();
            hz.delete();
            if (k != mesh_len - 1) break;
          end
        end
      end
    end

    // fill the store, then drive past it
    settle();
    write_thresh(26'd32);
    hx.delete();
    hy.delete();
    hz.delete();
    for (int k = 0; k < MAX_VERTICES + 4; k++) begin
      if (hx.size() != 0 && $urandom_range(4) == 0) begin
        pick = $urandom_range(hx.size() - 1);
        vx = coord_t'(int'(hx[pick]) + int'($urandom_range(0, 16)) - 8);
        vy = coord_t'(int'(hy[pick]) + int'($urandom_range(0, 16)) - 8);
        vz = coord_t'(int'(hz[pick]) + int'($urandom_range(0, 16)) - 8);
      end else begin
        vx = coord_t'($urandom);
        vy = coord_t'($urandom);
        vz = coord_t'($urandom);
      end
      hx.push_back(vx);
      hy.push_back(vy);
      hz.push_back(vz);
      send_vertex(vx, vy, vz, k == MAX_VERTICES + 3, 0, none);
    end
    for (int k = 0; k < 3; k++) begin
      send_vertex(hx[0], hy[0], hz[0], k == 2, 0, none);
    end

    vtx_valid <= 1'b0;
    while (pending_welds.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/vwim_pkg.sv
sv/vwim_ram.sv
sv/vwim_cell.sv
sv/vertex_weld_index_mapper_top.sv
sv/vwim_checker.sv
dv/vertex_weld_index_mapper_top_tb.sv
